// ===== src/dera_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dera_pkg
// Shared types, codes and helpers for the double-ended region allocator.
// ----------------------------------------------------------------------------
package dera_pkg;

  localparam int AddrWidth = 32;

  typedef logic [AddrWidth-1:0] addr_t;

  typedef enum logic [1:0] {
    OpAlloc      = 2'd0,
    OpRegister   = 2'd1,
    OpUnregister = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusNoSpace     = 2'd1,
    StatusAlreadyReg  = 2'd2,
    StatusNotReg      = 2'd3
  } status_e;

  typedef enum logic {
    SideBottom = 1'b0,
    SideTop    = 1'b1
  } side_e;

  typedef enum logic {
    RegRegionStart = 1'b0,
    RegRegionEnd   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    addr_t region_start;
    addr_t region_end;
  } region_t;

  typedef struct packed {
    addr_t bottom_top;
    addr_t top_top;
    logic  bottom_active;
    logic  top_active;
    addr_t low_water;
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic       side;
    addr_t      size;
  } item_t;

  typedef struct packed {
    status_e status;
    addr_t   block_address;
    addr_t   free_bytes;
    addr_t   low_water_free;
  } result_t;

  // Distance from lo up to hi, zero when the span is inverted.
  function automatic addr_t span(input addr_t lo, input addr_t hi);
    addr_t d;
    d = '0;
    if (hi >= lo) begin
      d = hi - lo;
    end
    return d;
  endfunction

  function automatic addr_t free_of(input region_t r, input state_t s);
    addr_t lo;
    addr_t hi;
    lo = s.bottom_active ? s.bottom_top : r.region_start;
    hi = s.top_active ? s.top_top : r.region_end;
    return span(lo, hi);
  endfunction

endpackage

// ===== src/double_ended_region_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_region_allocator
// Bottom-up and top-down bump allocators sharing one address region.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in       | input     | in_valid_i/in_ready_o  | operation_i, side_i, size_i
//  out      | output    | out_valid_o/out_ready_i| status_o, block_address_o,
//           |           |                        | free_bytes_o, low_water_free_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle while the output does not stall. An input transfer loads
// the input register; when the result register is empty or its result moves
// out, one pass of the step logic writes the result register, so an item goes
// through the input register and then the result register.
// The allocator state updates in the same cycle the item enters the result
// register. A stalled output holds its result; the input register still takes
// a new item while it is empty or while its item moves on at that edge.
// No clearing pass: the region, allocator state and valid flags reset at once.
// ----------------------------------------------------------------------------
module double_ended_region_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        side_i,
  input  logic [31:0] size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] block_address_o,
  output logic [31:0] free_bytes_o,
  output logic [31:0] low_water_free_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dera_pkg::region_t region_q, region_d;
  dera_pkg::state_t  state_q, state_d, step_state;
  dera_pkg::item_t   item_q;
  dera_pkg::result_t result_q, step_result;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_xfer, cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_xfer     = in_valid_i && in_ready_o;

  dera_step u_step (
    .region_i (region_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (step_state),
    .result_o (step_result)
  );

  always_comb begin
    region_d = region_q;
    state_d  = state_q;
    if (advance) begin
      state_d = step_state;
    end
    if (cfg_xfer) begin
      unique case (cfg_index_i)
        dera_pkg::RegRegionStart: region_d.region_start = cfg_data_i;
        dera_pkg::RegRegionEnd:   region_d.region_end   = cfg_data_i;
        default:                  region_d = region_q;
      endcase
      state_d.low_water = dera_pkg::span(region_d.region_start, region_d.region_end);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q    <= '0;
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      region_q <= region_d;
      state_q  <= state_d;
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.op   <= operation_i;
      item_q.side <= side_i;
      item_q.size <= size_i;
    end
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = result_q.status;
  assign block_address_o  = result_q.block_address;
  assign free_bytes_o     = result_q.free_bytes;
  assign low_water_free_o = result_q.low_water_free;

`ifndef SYNTHESIS
  // a failed or non-allocating result never carries a block base
  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != dera_pkg::StatusOk) |-> block_address_o == '0)
    else $error("failed item reports a block address");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && in_valid_q)
    else $error("input stalled without a held result");

  // low-water mark only rises through a configuration transfer
  a_low_water_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_xfer |=> state_q.low_water <= $past(state_q.low_water))
    else $error("low-water mark rose without a configuration write");

  // state only moves when an item advances or a configuration transfer lands
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance && !cfg_xfer |=> $stable(state_q))
    else $error("allocator state changed with no item or write");
`endif

endmodule

// ===== src/dera_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dera_step
// Next-state and result logic for one allocator item.
// ----------------------------------------------------------------------------
module dera_step (
  input  dera_pkg::region_t region_i,
  input  dera_pkg::state_t  state_i,
  input  dera_pkg::item_t   item_i,
  output dera_pkg::state_t  state_o,
  output dera_pkg::result_t result_o
);

  always_comb begin
    logic [dera_pkg::AddrWidth:0] up_sum;
    dera_pkg::addr_t              up_limit;
    dera_pkg::addr_t              dn_limit;
    dera_pkg::addr_t              dn_new;
    dera_pkg::addr_t              new_free;
    dera_pkg::addr_t              block;
    dera_pkg::status_e            status;
    logic                         up;
    logic                         side_active;

    state_o     = state_i;
    status      = dera_pkg::StatusOk;
    block       = '0;
    new_free    = '0;
    up          = (item_i.side == dera_pkg::SideBottom);
    side_active = up ? state_i.bottom_active : state_i.top_active;
    up_sum      = {1'b0, state_i.bottom_top} + {1'b0, item_i.size};
    up_limit    = state_i.top_active ? state_i.top_top : region_i.region_end;
    dn_limit    = state_i.bottom_active ? state_i.bottom_top : region_i.region_start;
    dn_new      = state_i.top_top - item_i.size;

    unique case (item_i.op)
      dera_pkg::OpRegister: begin
        if (side_active) begin
          status = dera_pkg::StatusAlreadyReg;
        end else if (up) begin
          state_o.bottom_active = 1'b1;
          state_o.bottom_top    = region_i.region_start;
        end else begin
          state_o.top_active = 1'b1;
          state_o.top_top    = region_i.region_end;
        end
      end
      dera_pkg::OpUnregister: begin
        if (!side_active) begin
          status = dera_pkg::StatusNotReg;
        end else if (up) begin
          state_o.bottom_active = 1'b0;
        end else begin
          state_o.top_active = 1'b0;
        end
      end
      dera_pkg::OpAlloc: begin
        if (!side_active) begin
          status = dera_pkg::StatusNotReg;
        end else if (up) begin
          // carry out means the top would wrap past the last address
          if (up_sum[dera_pkg::AddrWidth] ||
              (up_sum[dera_pkg::AddrWidth-1:0] > up_limit)) begin
            status = dera_pkg::StatusNoSpace;
          end else begin
            block              = state_i.bottom_top;
            state_o.bottom_top = up_sum[dera_pkg::AddrWidth-1:0];
            new_free           = up_limit - up_sum[dera_pkg::AddrWidth-1:0];
          end
        end else begin
          if ((item_i.size > state_i.top_top) || (dn_new < dn_limit)) begin
            status = dera_pkg::StatusNoSpace;
          end else begin
            block           = dn_new;
            state_o.top_top = dn_new;
            new_free        = dn_new - dn_limit;
          end
        end
        if ((status == dera_pkg::StatusOk) && (new_free < state_i.low_water)) begin
          state_o.low_water = new_free;
        end
      end
      default: begin
        // reserved code: no effect, reports ok
      end
    endcase

    result_o.status         = status;
    result_o.block_address  = block;
    result_o.free_bytes     = dera_pkg::free_of(region_i, state_o);
    result_o.low_water_free = state_o.low_water;
  end

endmodule
